>>> rtl/wer_enc_pkg.sv
// types and constants shared by the windowed error-rate encoder
`default_nettype none
package wer_enc_pkg;

  localparam logic [1:0] ACT_SPIKE = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_LOAD  = 2'd2;

  localparam logic [2:0] CFG_WINDOW_LENGTH   = 3'd0;
  localparam logic [2:0] CFG_POPULATION_SIZE = 3'd1;
  localparam logic [2:0] CFG_TABLE_LENGTH    = 3'd2;
  localparam logic [2:0] CFG_RUN_FOREVER     = 3'd3;
  localparam logic [2:0] CFG_RUN_LENGTH      = 3'd4;

  localparam logic [19:0] RATE_MIN  = 20'd65536;
  localparam logic [19:0] RATE_MAX  = 20'd655360;
  localparam logic [30:0] ACC_MAX   = 31'h7fff_ffff;
  localparam int          DIV_STEPS = 23;

  typedef struct packed {
    logic [1:0]         action;
    logic               key_lsb;
    logic [31:0]        spike_count;
    logic [9:0]         load_index;
    logic signed [31:0] load_position;
    logic signed [31:0] load_velocity;
  } enc_in_t;

  typedef struct packed {
    logic [5:0]         pair_index;
    logic [19:0]        ago_rate;
    logic [19:0]        anta_rate;
    logic signed [31:0] error_sum;
    logic [31:0]        left_total;
    logic [31:0]        right_total;
    logic               last_pair;
  } enc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAG,
    ST_MUL,
    ST_PAIR,
    ST_DIV,
    ST_EMIT
  } enc_state_t;

endpackage
`default_nettype wire

>>> rtl/windowed_error_rate_encoder.sv
// top level of the windowed error-rate encoder
`default_nettype none
// Spike and load transactions are accepted back to back in ST_IDLE. A tick that
// fills the window reads the head table (synchronous read), then forms the error and
// its scaled magnitude, then emits population_size/2 pairs, at most MAX_PAIRS: a pair
// at a rate limit passes ST_PAIR and ST_EMIT, a ramp pair also ST_DIV (23-step
// restoring divider shared by all pairs). No transaction is taken while pairs are
// produced; the last pair may wait in the output register while new transactions
// are accepted. The tables need no clearing pass after reset.
module windowed_error_rate_encoder #(
  parameter int TABLE_DEPTH = 1024,
  parameter int MAX_PAIRS   = 64
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wer_enc_pkg::enc_in_t  in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output wer_enc_pkg::enc_out_t out_data,
  input  wire                   cfg_we,
  input  wire [2:0]             cfg_index,
  input  wire [31:0]            cfg_data
);
  import wer_enc_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int PW = $clog2(MAX_PAIRS + 1);

  // configuration
  logic [15:0] window_length;
  logic [7:0]  population_size;
  logic [10:0] table_length;
  logic        run_forever;
  logic [31:0] run_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length   <= 16'd10;
      population_size <= 8'd128;
      table_length    <= 11'd1024;
      run_forever     <= 1'b1;
      run_length      <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_LENGTH:   window_length   <= cfg_data[15:0];
        CFG_POPULATION_SIZE: population_size <= cfg_data[7:0];
        CFG_TABLE_LENGTH:    table_length    <= cfg_data[10:0];
        CFG_RUN_FOREVER:     run_forever     <= cfg_data[0];
        CFG_RUN_LENGTH:      run_length      <= cfg_data;
        default: ;
      endcase
    end
  end

  enc_state_t state, state_next;

  logic [31:0] left_counter, right_counter, elapsed_ticks;
  logic [AW-1:0] head_index;
  logic [15:0] window_counter;
  logic [31:0] left_snap, right_snap;

  // head table memories
  logic [31:0] position_table [TABLE_DEPTH];
  logic [31:0] velocity_table [TABLE_DEPTH];
  logic [31:0] pos_rd, vel_rd;

  logic        in_fire, is_spike, is_tick, is_load;
  logic        tick_live, tick_fire;
  logic [31:0] load_idx_ext;
  logic        load_ok;
  logic [31:0] amount;
  logic [LW-1:0] limit;
  logic [AW:0] head_inc;
  logic [AW-1:0] head_next;
  logic [15:0] wc_inc;

  assign in_fire      = in_valid && in_ready;
  assign is_spike     = in_data.action == ACT_SPIKE;
  assign is_tick      = in_data.action == ACT_TICK;
  assign is_load      = in_data.action == ACT_LOAD;
  assign load_idx_ext = 32'(in_data.load_index);
  assign load_ok      = load_idx_ext < 32'(TABLE_DEPTH);
  assign amount       = (in_data.spike_count == 32'd0) ? 32'd1 : in_data.spike_count;
  assign tick_live    = run_forever || (elapsed_ticks < run_length);
  assign limit        = (table_length == 11'd0 || 32'(table_length) > 32'(TABLE_DEPTH))
                        ? LW'(TABLE_DEPTH) : LW'(table_length);
  assign head_inc     = {1'b0, head_index} + (AW+1)'(1);
  assign head_next    = (32'(head_inc) >= 32'(limit)) ? '0 : head_inc[AW-1:0];
  assign wc_inc       = window_counter + 16'd1;
  assign tick_fire    = in_fire && is_tick && tick_live && (wc_inc == window_length);

  always_ff @(posedge clk) begin
    if (in_fire && is_load && load_ok) begin
      position_table[load_idx_ext[AW-1:0]] <= in_data.load_position;
      velocity_table[load_idx_ext[AW-1:0]] <= in_data.load_velocity;
    end
    if (tick_fire) begin
      pos_rd <= position_table[head_next];
      vel_rd <= velocity_table[head_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_counter   <= '0;
      right_counter  <= '0;
      elapsed_ticks  <= '0;
      head_index     <= '0;
      window_counter <= '0;
    end else if (in_fire) begin
      if (is_spike) begin
        if (in_data.key_lsb) begin
          right_counter <= right_counter + amount;
        end else begin
          left_counter <= left_counter + amount;
        end
      end else if (is_tick && tick_live) begin
        elapsed_ticks <= elapsed_ticks + 32'd1;
        head_index    <= head_next;
        if (tick_fire) begin
          window_counter <= '0;
          left_counter   <= '0;
          right_counter  <= '0;
        end else begin
          window_counter <= wc_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      left_snap  <= left_counter;
      right_snap <= right_counter;
    end
  end

  // error, magnitude and scaled bounds
  logic signed [31:0] err;
  logic [30:0]        mag;
  logic [30:0]        low;
  logic [38:0]        prod;
  logic [21:0]        mid;
  logic signed [32:0] up;
  logic [PW-1:0]      pairs;
  logic [NW-1:0]      n;
  logic               n_last;
  logic [20:0]        lv;
  logic               above_up, below_low;
  logic signed [32:0] diff;

  assign prod  = 39'(mag) * 39'(population_size);
  assign mid   = {population_size, 14'd0};
  assign up    = $signed({2'b00, low}) - $signed({11'd0, mid});
  assign pairs = (32'(population_size >> 1) > 32'(MAX_PAIRS))
                 ? PW'(MAX_PAIRS) : PW'(population_size >> 1);
  assign n_last = (32'(n) + 32'd1) == 32'(pairs);
  assign lv    = {6'(n), 15'd0};
  assign above_up  = !($signed({12'd0, lv}) < up);
  assign below_low = 31'(lv) < low;
  assign diff  = $signed({12'd0, lv}) - up;

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      err <= pos_rd + vel_rd;
    end
    if (state == ST_MAG) begin
      if (err == 32'sh8000_0000) begin
        mag <= ACC_MAX;
      end else begin
        mag <= err[31] ? 31'(-err) : err[30:0];
      end
    end
    if (state == ST_MUL) begin
      low <= (prod[38:1] > 38'(ACC_MAX)) ? ACC_MAX : prod[31:1];
    end
  end

  // restoring divider: q = (2 * diff) / population_size
  logic [22:0] quo;
  logic [7:0]  rem;
  logic [8:0]  rem_sh;
  logic        rem_ge;
  logic [4:0]  div_cnt;
  logic [14:0] q;
  logic [19:0] rate;

  assign rem_sh = {rem, quo[22]};
  assign rem_ge = rem_sh >= {1'b0, population_size};
  assign q      = quo[14:0];

  logic div_start, pair_step, emit_load;

  always_ff @(posedge clk) begin
    if (div_start) begin
      quo     <= {diff[21:0], 1'b0};
      rem     <= '0;
      div_cnt <= '0;
    end else if (state == ST_DIV) begin
      quo     <= {quo[21:0], rem_ge};
      rem     <= rem_ge ? 8'(rem_sh - {1'b0, population_size}) : rem_sh[7:0];
      div_cnt <= div_cnt + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_step) begin
      if (!above_up) begin
        rate <= RATE_MAX;
      end else if (!below_low) begin
        rate <= RATE_MIN;
      end
    end else if (state == ST_DIV && div_cnt == 5'(DIV_STEPS)) begin
      rate <= RATE_MAX - (20'({q, 4'd0}) + 20'({q, 1'b0}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else if (state == ST_MUL) begin
      n <= '0;
    end else if (emit_load && !n_last) begin
      n <= n + NW'(1);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (tick_fire) state_next = ST_READ;
      ST_READ: state_next = ST_MAG;
      ST_MAG:  state_next = ST_MUL;
      ST_MUL:  state_next = (pairs == '0) ? ST_IDLE : ST_PAIR;
      ST_PAIR: state_next = (above_up && below_low) ? ST_DIV : ST_EMIT;
      ST_DIV:  if (div_cnt == 5'(DIV_STEPS)) state_next = ST_EMIT;
      ST_EMIT: if (emit_load) state_next = n_last ? ST_IDLE : ST_PAIR;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    pair_step = 1'b0;
    emit_load = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_PAIR: begin
        pair_step = 1'b1;
        div_start = above_up && below_low;
      end
      ST_EMIT: emit_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_data.pair_index  <= 6'(n);
      out_data.ago_rate    <= err[31] ? rate : RATE_MIN;
      out_data.anta_rate   <= err[31] ? RATE_MIN : rate;
      out_data.error_sum   <= err;
      out_data.left_total  <= left_snap;
      out_data.right_total <= right_snap;
      out_data.last_pair   <= n_last;
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.error_sum[31] ? out_data.anta_rate == RATE_MIN
                                          : out_data.ago_rate == RATE_MIN))
    else $error("both rates of a pair above minimum");

  a_rate_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.ago_rate >= RATE_MIN && out_data.ago_rate <= RATE_MAX
                && out_data.anta_rate >= RATE_MIN
                && out_data.anta_rate <= RATE_MAX))
    else $error("rate out of range");

  a_fire_reads: assert property (@(posedge clk) disable iff (rst)
    tick_fire |=> state == ST_READ)
    else $error("window fire did not start table read");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> div_cnt <= 5'(DIV_STEPS))
    else $error("divider ran past its step count");

endmodule
`default_nettype wire
